FILE: rtl/tlbr_pkg.sv
`default_nettype none

package tlbr_pkg;

    // Geometry
    localparam int TLB_DEPTH = 16;
    localparam int IDX_W     = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
    localparam int CNT_W     = $clog2(TLB_DEPTH + 1);

    // Field widths
    localparam int PROC_W  = 16;
    localparam int PAGE_W  = 20;
    localparam int FRAME_W = 20;
    localparam int AGE_W   = 16;
    localparam int ORDER_W = 32;
    localparam int SLOT_W  = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int ENT_W      = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 1'd1;
    localparam logic [ENT_W-1:0]     ENTRIES_RESET      = 5'd16;

    // Request kinds and replacement modes
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_FILL   = 1'b1;
    localparam logic MODE_LRU    = 1'b0;
    localparam logic MODE_FIFO   = 1'b1;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // Request held stable while the scan runs
    typedef struct packed {
        logic               kind;
        logic [PROC_W-1:0]  proc_id;
        logic [PAGE_W-1:0]  page_num;
        logic [FRAME_W-1:0] frame;
    } t_req;

    // Scan token handed from cell to cell
    typedef struct packed {
        logic               valid;
        logic               done;   // request settled (hit or free entry written)
        logic               have;   // a victim candidate is held
        logic               hit;
        logic [IDX_W-1:0]   idx;    // hit/written entry, or best victim so far
        logic [ORDER_W-1:0] key;    // age or insertion number of the candidate
        logic [FRAME_W-1:0] frame;
    } t_tok;

    // Victim write broadcast
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic [ORDER_W-1:0] order;
    } t_wr;

    // Result register
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic [FRAME_W-1:0] frame;
        logic [SLOT_W-1:0]  slot;
        logic               evicted;
    } t_res;

endpackage

`default_nettype wire

FILE: rtl/tlbr_cell.sv
`default_nettype none

module tlbr_cell import tlbr_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IDX_W-1:0] i_index,
    input  wire logic [CNT_W-1:0] i_active_n,
    input  wire logic             i_mode,
    input  wire t_req             i_req,
    input  wire t_wr              i_wr,
    input  wire t_tok             i_tok,
    output t_tok                  o_tok
);

    logic               r_valid, n_valid;
    logic [PROC_W-1:0]  r_proc, n_proc;
    logic [PAGE_W-1:0]  r_page, n_page;
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic [AGE_W-1:0]   r_age, n_age;
    logic [ORDER_W-1:0] r_order, n_order;
    t_tok               r_tok, n_tok;

    logic               active;
    logic               work;
    logic               match;
    logic [ORDER_W-1:0] key;
    logic               better;

    assign active = (CNT_W'(i_index) < i_active_n);
    assign work   = i_tok.valid && active && !i_tok.done;
    assign match  = r_valid && (r_proc == i_req.proc_id) && (r_page == i_req.page_num);
    assign key    = (i_mode == MODE_FIFO) ? r_order : ORDER_W'(r_age);

    // strict compare keeps the first entry on ties
    always_comb begin
        if (!i_tok.have) begin
            better = 1'b1;
        end else if (i_mode == MODE_FIFO) begin
            better = (key < i_tok.key);
        end else begin
            better = (key > i_tok.key);
        end
    end

    // entry update and token hand-off
    always_comb begin
        n_valid = r_valid;
        n_proc  = r_proc;
        n_page  = r_page;
        n_frame = r_frame;
        n_age   = r_age;
        n_order = r_order;
        n_tok   = i_tok;

        if (work) begin
            if (i_req.kind == KIND_LOOKUP) begin
                if (r_age != AGE_MAX) begin
                    n_age = r_age + AGE_W'(1);
                end
                if (match) begin
                    n_age       = '0;
                    n_tok.done  = 1'b1;
                    n_tok.hit   = 1'b1;
                    n_tok.frame = r_frame;
                    n_tok.idx   = i_index;
                end
            end else if (!r_valid) begin
                // first free entry takes the fill
                n_valid    = 1'b1;
                n_proc     = i_req.proc_id;
                n_page     = i_req.page_num;
                n_frame    = i_req.frame;
                n_age      = '0;
                n_order    = ORDER_W'(i_index);
                n_tok.done = 1'b1;
                n_tok.idx  = i_index;
            end else if (better) begin
                n_tok.have = 1'b1;
                n_tok.key  = key;
                n_tok.idx  = i_index;
            end
        end

        // replacement write after a full scan
        if (i_wr.en && (i_wr.idx == i_index)) begin
            n_valid = 1'b1;
            n_proc  = i_req.proc_id;
            n_page  = i_req.page_num;
            n_frame = i_req.frame;
            n_age   = '0;
            n_order = i_wr.order;
        end
    end

    // control and replacement state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_age       <= '0;
            r_order     <= '0;
            r_tok.valid <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_age       <= n_age;
            r_order     <= n_order;
            r_tok.valid <= n_tok.valid;
        end
    end

    // translation payload and token payload
    always_ff @(posedge i_clk) begin
        r_proc      <= n_proc;
        r_page      <= n_page;
        r_frame     <= n_frame;
        r_tok.done  <= n_tok.done;
        r_tok.have  <= n_tok.have;
        r_tok.hit   <= n_tok.hit;
        r_tok.idx   <= n_tok.idx;
        r_tok.key   <= n_tok.key;
        r_tok.frame <= n_tok.frame;
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

FILE: rtl/tlbr_ctrl.sv
`default_nettype none

module tlbr_ctrl import tlbr_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_kind,
    input  wire logic [PROC_W-1:0]     i_proc_id,
    input  wire logic [PAGE_W-1:0]     i_page_num,
    input  wire logic [FRAME_W-1:0]    i_frame_in,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_req                       o_req,
    output logic                       o_mode,
    output logic [CNT_W-1:0]           o_active_n,
    output t_tok                       o_tok,
    input  wire t_tok                  i_tok,
    output t_wr                        o_wr,
    output t_res                       o_res
);

    t_state             r_state, n_state;
    t_req               r_req, n_req;
    t_tok               r_tok0, n_tok0;
    t_res               r_res, n_res;
    logic [ORDER_W-1:0] r_order_cnt, n_order_cnt;
    logic               r_mode;
    logic [ENT_W-1:0]   r_entries;
    logic [CNT_W-1:0]   active_n;
    logic [ORDER_W-1:0] order_next;

    // active entry count, clamped to the array depth
    always_comb begin
        if (32'(r_entries) > 32'(TLB_DEPTH)) begin
            active_n = CNT_W'(TLB_DEPTH);
        end else begin
            active_n = CNT_W'(r_entries);
        end
    end

    assign order_next = r_order_cnt + ORDER_W'(1);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_LRU;
            r_entries <= ENTRIES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REPLACE_MODE:   r_mode    <= i_cfg_data[0];
                CFG_ENTRIES_IN_USE: r_entries <= i_cfg_data[ENT_W-1:0];
                default:            ;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, token launch and result
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_tok0      = '0;
        n_res       = '0;
        n_order_cnt = r_order_cnt;
        o_wr        = '0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_req.kind     = i_kind;
                    n_req.proc_id  = i_proc_id;
                    n_req.page_num = i_page_num;
                    n_req.frame    = i_frame_in;
                    if (active_n == '0) begin
                        // disabled: all-zero result, no state change
                        n_res.valid = 1'b1;
                    end else begin
                        n_tok0.valid = 1'b1;
                        n_state      = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (i_tok.valid) begin
                    n_state     = ST_IDLE;
                    n_res.valid = 1'b1;
                    if (r_req.kind == KIND_LOOKUP) begin
                        n_res.hit   = i_tok.hit;
                        n_res.frame = i_tok.frame;
                        n_res.slot  = i_tok.hit ? SLOT_W'(i_tok.idx) : '0;
                    end else if (i_tok.done) begin
                        // fill went to a free entry
                        n_res.slot  = SLOT_W'(i_tok.idx);
                        n_order_cnt = ORDER_W'(i_tok.idx);
                    end else begin
                        // no free entry: replace the victim
                        o_wr.en       = 1'b1;
                        o_wr.idx      = i_tok.idx;
                        o_wr.order    = order_next;
                        n_order_cnt   = order_next;
                        n_res.slot    = SLOT_W'(i_tok.idx);
                        n_res.evicted = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok0.valid <= 1'b0;
            r_res.valid  <= 1'b0;
            r_order_cnt  <= '0;
        end else begin
            r_tok0.valid <= n_tok0.valid;
            r_res.valid  <= n_res.valid;
            r_order_cnt  <= n_order_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req         <= n_req;
        r_tok0.done   <= n_tok0.done;
        r_tok0.have   <= n_tok0.have;
        r_tok0.hit    <= n_tok0.hit;
        r_tok0.idx    <= n_tok0.idx;
        r_tok0.key    <= n_tok0.key;
        r_tok0.frame  <= n_tok0.frame;
        r_res.hit     <= n_res.hit;
        r_res.frame   <= n_res.frame;
        r_res.slot    <= n_res.slot;
        r_res.evicted <= n_res.evicted;
    end

    assign busy       = (r_state == ST_SCAN);
    assign o_req      = r_req;
    assign o_mode     = r_mode;
    assign o_active_n = active_n;
    assign o_tok      = r_tok0;
    assign o_res      = r_res;

endmodule

`default_nettype wire

FILE: rtl/tlb_lru_fifo_replacement_core.sv
// Fully associative TLB keyed by process id and page, with LRU or FIFO
// replacement. A request is taken when start is high and busy is low. The
// result appears on o_valid for exactly one cycle and cannot be stalled, so
// the receiver must take it when it comes. A request walks a row of
// TLB_DEPTH entry cells, one cell per cycle, passing from the launch
// register through the cells to the result register, and busy is low again
// in the cycle the result shows. With entries_in_use at zero the TLB is
// off: the all-zero result follows in the cycle after the request and busy
// stays low. Configuration writes go through i_cfg_we, i_cfg_idx and
// i_cfg_data and must only happen while no request is pending.
`default_nettype none

module tlb_lru_fifo_replacement_core import tlbr_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_kind,
    input  wire logic [PROC_W-1:0]     i_proc_id,
    input  wire logic [PAGE_W-1:0]     i_page_num,
    input  wire logic [FRAME_W-1:0]    i_frame_in,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_valid,
    output logic                       o_hit,
    output logic [FRAME_W-1:0]         o_frame_out,
    output logic [SLOT_W-1:0]          o_slot,
    output logic                       o_evicted
);

    t_req             w_req;
    t_wr              w_wr;
    t_res             w_res;
    logic             w_mode;
    logic [CNT_W-1:0] w_active_n;
    t_tok             w_tok [0:TLB_DEPTH];

    // sequencer and configuration
    tlbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_kind     (i_kind),
        .i_proc_id  (i_proc_id),
        .i_page_num (i_page_num),
        .i_frame_in (i_frame_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_req      (w_req),
        .o_mode     (w_mode),
        .o_active_n (w_active_n),
        .o_tok      (w_tok[0]),
        .i_tok      (w_tok[TLB_DEPTH]),
        .o_wr       (w_wr),
        .o_res      (w_res)
    );

    // row of entry cells, token moves one cell per cycle
    for (genvar k = 0; k < TLB_DEPTH; k++) begin : g_cell
        tlbr_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_index    (IDX_W'(k)),
            .i_active_n (w_active_n),
            .i_mode     (w_mode),
            .i_req      (w_req),
            .i_wr       (w_wr),
            .i_tok      (w_tok[k]),
            .o_tok      (w_tok[k+1])
        );
    end

    assign o_valid     = w_res.valid;
    assign o_hit       = w_res.hit;
    assign o_frame_out = w_res.frame;
    assign o_slot      = w_res.slot;
    assign o_evicted   = w_res.evicted;

endmodule

`default_nettype wire

FILE: dv/tb_tlb_lru_fifo_replacement_core.sv
`timescale 1ns / 100ps

module tb_tlb_lru_fifo_replacement_core import tlbr_pkg::*;;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 1500;
    localparam int MAX_REPORTS = 40;

    // Expected translation result
    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
        logic [SLOT_W-1:0]  slot;
        logic               evicted;
    } t_xlat;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    logic                  i_kind      = 1'b0;
    logic [PROC_W-1:0]     i_proc_id   = '0;
    logic [PAGE_W-1:0]     i_page_num  = '0;
    logic [FRAME_W-1:0]    i_frame_in  = '0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_valid;
    logic                  o_hit;
    logic [FRAME_W-1:0]    o_frame_out;
    logic [SLOT_W-1:0]     o_slot;
    logic                  o_evicted;

    // Shadow TLB state and configuration
    logic               tlb_valid [TLB_DEPTH];
    logic [PROC_W-1:0]  tlb_proc  [TLB_DEPTH];
    logic [PAGE_W-1:0]  tlb_page  [TLB_DEPTH];
    logic [FRAME_W-1:0] tlb_frame [TLB_DEPTH];
    logic [AGE_W-1:0]   tlb_age   [TLB_DEPTH];
    logic [ORDER_W-1:0] tlb_order [TLB_DEPTH];
    logic [ORDER_W-1:0] insert_ctr = '0;
    logic               cfg_mode   = MODE_LRU;
    logic [ENT_W-1:0]   cfg_count  = ENTRIES_RESET;

    t_req  pending_reqs [$];
    t_xlat expected_xlat[$];
    t_req  cur_req;
    bit    presenting = 1'b0;
    bit    req_taken  = 1'b0;
    bit    busy_q     = 1'b1;
    bit    no_idle    = 1'b0;
    int    gap_left   = 0;
    int    cycles     = 0;
    int    mismatches = 0;

    tlb_lru_fifo_replacement_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_proc_id   (i_proc_id),
        .i_page_num  (i_page_num),
        .i_frame_in  (i_frame_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_hit       (o_hit),
        .o_frame_out (o_frame_out),
        .o_slot      (o_slot),
        .o_evicted   (o_evicted)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        for (int k = 0; k < TLB_DEPTH; k++) begin
            tlb_valid[k] = 1'b0;
            tlb_age[k]   = '0;
            tlb_order[k] = '0;
        end
    end

    // Write one shadow entry with a fresh age
    function automatic void store_entry(int k, t_req rq, logic [ORDER_W-1:0] ord);
        tlb_valid[k] = 1'b1;
        tlb_proc[k]  = rq.proc_id;
        tlb_page[k]  = rq.page_num;
        tlb_frame[k] = rq.frame;
        tlb_order[k] = ord;
        tlb_age[k]   = '0;
    endfunction

    // Lookup or fill against the shadow TLB; returns the result it causes
    function automatic t_xlat translate_req(t_req rq);
        t_xlat r;
        int    n;
        int    victim;
        r = '0;
        n = (cfg_count > TLB_DEPTH) ? TLB_DEPTH : int'(cfg_count);
        if (n == 0)
            return r;
        if (rq.kind == KIND_LOOKUP) begin
            // ages rise up to and including the first match
            for (int k = 0; k < n; k++) begin
                if (tlb_age[k] != AGE_MAX)
                    tlb_age[k] = tlb_age[k] + 1'b1;
                if (tlb_valid[k] && tlb_proc[k] == rq.proc_id && tlb_page[k] == rq.page_num) begin
                    tlb_age[k] = '0;
                    r.hit   = 1'b1;
                    r.frame = tlb_frame[k];
                    r.slot  = SLOT_W'(k);
                    return r;
                end
            end
            return r;
        end
        // lowest free entry first
        for (int k = 0; k < n; k++) begin
            if (!tlb_valid[k]) begin
                insert_ctr = ORDER_W'(k);
                store_entry(k, rq, insert_ctr);
                r.slot = SLOT_W'(k);
                return r;
            end
        end
        // full: oldest age or lowest insertion number, first wins ties
        victim = 0;
        for (int k = 1; k < n; k++) begin
            if (cfg_mode == MODE_LRU) begin
                if (tlb_age[k] > tlb_age[victim])
                    victim = k;
            end else begin
                if (tlb_order[k] < tlb_order[victim])
                    victim = k;
            end
        end
        insert_ctr = insert_ctr + 1'b1;
        store_entry(victim, rq, insert_ctr);
        r.slot    = SLOT_W'(victim);
        r.evicted = 1'b1;
        return r;
    endfunction

    task automatic note_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want) begin
            if (mismatches < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: check results, record accepted requests
    always @(posedge i_clk) begin : mon
        t_xlat want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
            busy_q    <= 1'b1;
        end else if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("*** FAILED ***");
            $finish;
        end else begin
            cycles++;
            busy_q <= busy;
            if (o_valid) begin
                if (expected_xlat.size() == 0) begin
                    $display("%0t: expected no result, actual hit %0b frame %0h slot %0h",
                             $time, o_hit, o_frame_out, o_slot);
                    mismatches++;
                end else begin
                    want = expected_xlat.pop_front();
                    note_field("hit", 32'(want.hit), 32'(o_hit));
                    note_field("frame_out", 32'(want.frame), 32'(o_frame_out));
                    note_field("slot", 32'(want.slot), 32'(o_slot));
                    note_field("evicted", 32'(want.evicted), 32'(o_evicted));
                end
            end
            if (start && !busy) begin
                expected_xlat.push_back(translate_req(cur_req));
                req_taken <= 1'b1;
            end else begin
                req_taken <= 1'b0;
            end
        end
    end

    // Driver: present queued requests with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (req_taken) begin
                presenting = 1'b0;
                gap_left   = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (!presenting && gap_left != 0 && !busy_q)
                gap_left--;
            if (!presenting && gap_left == 0 && pending_reqs.size() != 0) begin
                cur_req    = pending_reqs.pop_front();
                presenting = 1'b1;
            end
            start <= presenting;
            if (presenting) begin
                i_kind     <= cur_req.kind;
                i_proc_id  <= cur_req.proc_id;
                i_page_num <= cur_req.page_num;
                i_frame_in <= cur_req.frame;
            end else begin
                i_kind     <= 1'($urandom);
                i_proc_id  <= PROC_W'($urandom);
                i_page_num <= PAGE_W'($urandom);
                i_frame_in <= FRAME_W'($urandom);
            end
        end
    end

    task automatic queue_req(input logic kind, input logic [PROC_W-1:0] pid,
                             input logic [PAGE_W-1:0] pg, input logic [FRAME_W-1:0] fr);
        t_req rq;
        rq.kind     = kind;
        rq.proc_id  = pid;
        rq.page_num = pg;
        rq.frame    = fr;
        pending_reqs.push_back(rq);
    endtask

    // Returns at a falling edge once every request has its result
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || presenting || expected_xlat.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_config(input logic mode, input logic [ENT_W-1:0] count);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_REPLACE_MODE;
        i_cfg_data <= {4'($urandom), mode};
        @(negedge i_clk);
        i_cfg_idx  <= CFG_ENTRIES_IN_USE;
        i_cfg_data <= count;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_mode   = mode;
        cfg_count  = count;
    endtask

    // Stimulus
    initial begin
        logic [PROC_W-1:0] pool_proc [24];
        logic [PAGE_W-1:0] pool_page [24];
        logic [PROC_W-1:0] pid;
        logic [PAGE_W-1:0] pg;
        logic              mode;
        logic [ENT_W-1:0]  count;
        int                phase;
        int                rand_done;
        int                n_items;
        int                pool_n;
        int                sel;
        int                roll;
        int                bpos;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: LRU, all 16 entries
        queue_req(KIND_LOOKUP, '0, '0, '1);                  // empty TLB misses
        queue_req(KIND_FILL, '0, '0, '0);
        queue_req(KIND_FILL, '1, '1, '1);
        // two entries, both age zero: LRU picks entry 0
        set_config(MODE_LRU, 5'd2);
        queue_req(KIND_FILL, '0, '0, 20'hABCDE);
        queue_req(KIND_LOOKUP, '0, '0, '1);
        queue_req(KIND_LOOKUP, '1, '1, '0);
        queue_req(KIND_LOOKUP, '1, '0, '0);                  // page matches, proc does not
        queue_req(KIND_FILL, 16'h1234, 20'h56789, 20'h00009);
        // FIFO, full
        set_config(MODE_FIFO, 5'd2);
        queue_req(KIND_FILL, 16'h8000, 20'h80000, 20'h7FFFF);
        queue_req(KIND_FILL, 16'h0001, 20'h00001, 20'h80000);
        queue_req(KIND_LOOKUP, 16'h8000, 20'h80000, '0);
        // disabled TLB
        set_config(MODE_FIFO, 5'd0);
        queue_req(KIND_LOOKUP, 16'h0001, 20'h00001, '0);
        queue_req(KIND_FILL, 16'hAAAA, 20'h55555, 20'hAAAAA);
        // oversized count acts as full depth
        set_config(MODE_LRU, 5'd31);
        queue_req(KIND_LOOKUP, 16'h0001, 20'h00001, '0);
        queue_req(KIND_FILL, 16'h5555, 20'hAAAAA, 20'h55555);
        queue_req(KIND_FILL, 16'h0001, 20'h00001, 20'h12345);  // duplicate translation
        queue_req(KIND_LOOKUP, 16'h0001, 20'h00001, '0);
        // shrink: upper entries hidden, then visible again
        set_config(MODE_LRU, 5'd1);
        queue_req(KIND_FILL, 16'h0F0F, 20'hF0F0F, 20'h0F0F0);
        queue_req(KIND_LOOKUP, 16'h5555, 20'hAAAAA, '0);
        set_config(MODE_LRU, 5'd16);
        queue_req(KIND_LOOKUP, 16'h5555, 20'hAAAAA, '0);

        // Random phases over a small key pool so lookups hit and fills evict
        rand_done = 0;
        phase     = 0;
        while (rand_done < RAND_ITEMS) begin
            mode = 1'($urandom);
            roll = $urandom_range(0, 9);
            if (phase < 2) begin
                mode  = (phase == 0) ? MODE_LRU : MODE_FIFO;
                count = 5'd16;
            end else if (roll == 0) begin
                count = 5'd0;
            end else if (roll == 1) begin
                count = 5'($urandom_range(17, 31));
            end else if (roll < 6) begin
                count = 5'($urandom_range(1, 4));
            end else if (roll < 8) begin
                count = 5'($urandom_range(5, 15));
            end else begin
                count = 5'd16;
            end
            set_config(mode, count);
            no_idle = ($urandom_range(0, 3) == 0);
            pool_n  = $urandom_range(2, 24);
            for (int k = 0; k < pool_n; k++) begin
                pool_proc[k] = PROC_W'($urandom);
                pool_page[k] = PAGE_W'($urandom);
            end
            n_items = (count == 0) ? 20 : 100;
            for (int i = 0; i < n_items; i++) begin
                sel  = $urandom_range(0, pool_n - 1);
                pid  = pool_proc[sel];
                pg   = pool_page[sel];
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    pid = PROC_W'($urandom);
                    pg  = PAGE_W'($urandom);
                end else if (roll < 15) begin
                    // near miss: one bit off a known key
                    if ($urandom_range(0, 1)) begin
                        bpos      = $urandom_range(0, PROC_W - 1);
                        pid[bpos] = ~pid[bpos];
                    end else begin
                        bpos     = $urandom_range(0, PAGE_W - 1);
                        pg[bpos] = ~pg[bpos];
                    end
                end
                queue_req(($urandom_range(0, 99) < 40) ? KIND_FILL : KIND_LOOKUP,
                          pid, pg, FRAME_W'($urandom));
            end
            if (count != 0)
                rand_done += n_items;
            phase++;
        end

        wait_idle();
        repeat (TLB_DEPTH + 4) @(posedge i_clk);
        if (mismatches == 0 && expected_xlat.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
